### sv/at_cfr_pkg.sv
// shared types, constants and the command pattern list of the frame recogniser
package at_cfr_pkg;

   localparam int FRAME_BYTES   = 20;
   localparam int IDX_W         = $clog2(FRAME_BYTES);
   localparam int VIEW_BYTES    = 14;
   localparam int CMP_W         = 4;
   localparam int PATTERN_COUNT = 20;
   localparam int PATTERN_IDX_W = $clog2(PATTERN_COUNT);

   localparam logic [7:0] CHAR_A  = 8'h41;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef enum logic [4:0] {
      CMD_AT         = 5'd0,
      CMD_AT_R       = 5'd1,
      CMD_AS         = 5'd2,
      CMD_AB         = 5'd3,
      CMD_AR         = 5'd4,
      CMD_AX         = 5'd5,
      CMD_AY         = 5'd6,
      CMD_AA         = 5'd7,
      CMD_PRINT_DATA = 5'd8,
      CMD_NOHEAT     = 5'd9,
      CMD_HF         = 5'd10,
      CMD_AME        = 5'd11,
      CMD_AMEN       = 5'd12,
      CMD_AMC        = 5'd13,
      CMD_AWR1       = 5'd14,
      CMD_AWR2       = 5'd15,
      CMD_AAGE       = 5'd16,
      CMD_ACAF       = 5'd17,
      CMD_AGYS       = 5'd18,
      CMD_ATFLASH    = 5'd19,
      CMD_UNKNOWN    = 5'd20
   } command_type;

   typedef logic [0:VIEW_BYTES-1][7:0] text_type;

   typedef struct packed {
      text_type          text;
      logic [IDX_W-1:0]  len;
      logic [CMP_W-1:0]  cmp;
      command_type       code;
   } pattern_type;

   // frame as seen after the current byte is written
   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  length;
      text_type          bytes;
   } frame_view_type;

   typedef struct packed {
      command_type       command;
      logic [31:0]       payload;
      logic              payload_is_nan;
   } result_type;

   // text is left-aligned, only the first cmp bytes are compared
   function automatic pattern_type pattern(input logic [PATTERN_IDX_W-1:0] idx);
      pattern_type p;
      p = '{text: '0, len: '0, cmp: '0, code: CMD_UNKNOWN};
      case (idx)
         5'd0: p = '{{"AT\r\n", {10{8'h00}}}, IDX_W'(4), CMP_W'(4), CMD_AT};
         5'd1: p = '{{"AT+R\r\n", {8{8'h00}}}, IDX_W'(6), CMP_W'(6), CMD_AT_R};
         5'd2: p = '{{"AS\r\n", {10{8'h00}}}, IDX_W'(4), CMP_W'(4), CMD_AS};
         5'd3: p = '{{"AB\r\n", {10{8'h00}}}, IDX_W'(4), CMP_W'(4), CMD_AB};
         5'd4: p = '{{"AR\r\n", {10{8'h00}}}, IDX_W'(4), CMP_W'(4), CMD_AR};
         5'd5: p = '{{"AX", {12{8'h00}}}, IDX_W'(8), CMP_W'(2), CMD_AX};
         5'd6: p = '{{"AY", {12{8'h00}}}, IDX_W'(8), CMP_W'(2), CMD_AY};
         5'd7: p = '{{"AA", {12{8'h00}}}, IDX_W'(8), CMP_W'(2), CMD_AA};
         5'd8: p = '{"AT+printData\r\n", IDX_W'(14), CMP_W'(14), CMD_PRINT_DATA};
         5'd9: p = '{{"AT+noheat\r\n", {3{8'h00}}}, IDX_W'(11), CMP_W'(11), CMD_NOHEAT};
         5'd10: p = '{{"AT+hf\r\n", {7{8'h00}}}, IDX_W'(7), CMP_W'(7), CMD_HF};
         5'd11: p = '{{"AME", {11{8'h00}}}, IDX_W'(5), CMP_W'(3), CMD_AME};
         5'd12: p = '{{"AMEN", {10{8'h00}}}, IDX_W'(6), CMP_W'(4), CMD_AMEN};
         5'd13: p = '{{"AMC", {11{8'h00}}}, IDX_W'(5), CMP_W'(3), CMD_AMC};
         5'd14: p = '{{"AWR1", {10{8'h00}}}, IDX_W'(10), CMP_W'(4), CMD_AWR1};
         5'd15: p = '{{"AWR2", {10{8'h00}}}, IDX_W'(10), CMP_W'(4), CMD_AWR2};
         5'd16: p = '{{"AAGE", {10{8'h00}}}, IDX_W'(10), CMP_W'(4), CMD_AAGE};
         5'd17: p = '{{"ACAF", {10{8'h00}}}, IDX_W'(10), CMP_W'(4), CMD_ACAF};
         5'd18: p = '{{"AGYS", {10{8'h00}}}, IDX_W'(10), CMP_W'(4), CMD_AGYS};
         5'd19: p = '{{"ATFLASH", {7{8'h00}}}, IDX_W'(9), CMP_W'(7), CMD_ATFLASH};
         default: p = '{text: '0, len: '0, cmp: '0, code: CMD_UNKNOWN};
      endcase
      return p;
   endfunction

endpackage

### sv/at_command_frame_recognizer.sv
// top level of the command frame recogniser
// Takes one received byte per item and gives one result when a CR LF closes a
// frame: the command code (20 for an unknown frame), a 32-bit little-endian
// payload for the AX/AY/AA and AWR1/AWR2/AAGE/ACAF/AGYS commands, and a flag
// that the payload is an IEEE single NaN. Bytes that close no frame give no
// result. A byte is held in the input register and its result is then
// written to the output register. One byte is taken every cycle while the
// result is not blocked; the frame store, its index and all pattern
// compares are updated as the byte leaves the input register. The store
// is cleared after every result and whenever its first byte is not 'A'.
module at_command_frame_recognizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_command,
   output logic [31:0] rsp_payload,
   output logic        rsp_payload_is_nan
);

   logic                       in_valid;
   logic [7:0]                 in_byte;
   logic                       advance;
   at_cfr_pkg::frame_view_type view;
   at_cfr_pkg::result_type     result;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   at_cfr_pkg::result_type     out_ff;

   assign advance = in_valid && (!out_valid_ff || rsp_ready);

   at_cfr_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   at_cfr_frame_store u_frame_store (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte),
      .view    (view)
   );

   at_cfr_classify u_classify (
      .view   (view),
      .result (result)
   );

   always_comb begin
      if (advance) begin
         out_valid_in = view.hit;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && view.hit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_command        = out_ff.command;
   assign rsp_payload        = out_ff.payload;
   assign rsp_payload_is_nan = out_ff.payload_is_nan;

`ifndef SYNTHESIS
   a_hit_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && view.hit |=> rsp_valid)
      else $error("frame end did not produce a result item");

   a_command_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_command <= 5'(at_cfr_pkg::CMD_UNKNOWN)))
      else $error("command code out of range");

   a_payload_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload != 32'd0) |->
         ((rsp_command >= 5'(at_cfr_pkg::CMD_AX)) && (rsp_command <= 5'(at_cfr_pkg::CMD_AA)))
         || ((rsp_command >= 5'(at_cfr_pkg::CMD_AWR1))
             && (rsp_command <= 5'(at_cfr_pkg::CMD_AGYS))))
      else $error("payload on a command that carries none");

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid && rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked result");
`endif

endmodule

### sv/at_cfr_in_reg.sv
// input register of the frame recogniser
module at_cfr_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       advance,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

### sv/at_cfr_frame_store.sv
// frame store, write index and CR LF end-of-frame detection
module at_cfr_frame_store (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [7:0]                 in_byte,
   output at_cfr_pkg::frame_view_type view
);

   logic [7:0]                   store_ff [at_cfr_pkg::FRAME_BYTES];
   logic [at_cfr_pkg::IDX_W-1:0] index_ff;
   logic [at_cfr_pkg::IDX_W-1:0] index_in;
   logic [7:0]                   prev_ff;
   logic [7:0]                   first_byte;
   logic                         clear;
   logic                         hit;
   at_cfr_pkg::text_type         view_bytes;

   always_comb begin
      if (index_ff == at_cfr_pkg::IDX_W'(at_cfr_pkg::FRAME_BYTES - 1)) begin
         index_in = '0;
      end else begin
         index_in = index_ff + 1'b1;
      end
   end

   // bytes as they stand once the current byte is written
   always_comb begin
      for (int k = 0; k < at_cfr_pkg::VIEW_BYTES; k++) begin
         if (index_ff == at_cfr_pkg::IDX_W'(k)) begin
            view_bytes[k] = in_byte;
         end else begin
            view_bytes[k] = store_ff[k];
         end
      end
   end

   assign first_byte = view_bytes[0];
   // the byte stored just before is the one in prev_ff while the index is above 1
   assign hit        = (index_in > at_cfr_pkg::IDX_W'(1))
                       && (in_byte == at_cfr_pkg::CHAR_LF)
                       && (prev_ff == at_cfr_pkg::CHAR_CR);
   assign clear      = hit || (first_byte != at_cfr_pkg::CHAR_A);
   assign view       = '{hit: hit, length: index_in, bytes: view_bytes};

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         prev_ff  <= '0;
         for (int k = 0; k < at_cfr_pkg::FRAME_BYTES; k++) begin
            store_ff[k] <= '0;
         end
      end else if (advance) begin
         prev_ff <= in_byte;
         if (clear) begin
            index_ff <= '0;
            for (int k = 0; k < at_cfr_pkg::FRAME_BYTES; k++) begin
               store_ff[k] <= '0;
            end
         end else begin
            index_ff           <= index_in;
            store_ff[index_ff] <= in_byte;
         end
      end
   end

endmodule

### sv/at_cfr_classify.sv
// command pattern match, payload extraction and nan test
module at_cfr_classify (
   input  at_cfr_pkg::frame_view_type view,
   output at_cfr_pkg::result_type     result
);

   logic [at_cfr_pkg::PATTERN_COUNT-1:0] match;
   at_cfr_pkg::command_type              code;
   logic [31:0]                          payload;

   always_comb begin
      at_cfr_pkg::pattern_type p;
      for (int i = 0; i < at_cfr_pkg::PATTERN_COUNT; i++) begin
         p        = at_cfr_pkg::pattern(at_cfr_pkg::PATTERN_IDX_W'(i));
         match[i] = (view.length == p.len);
         for (int j = 0; j < at_cfr_pkg::VIEW_BYTES; j++) begin
            if ((at_cfr_pkg::CMP_W'(j) < p.cmp) && (view.bytes[j] != p.text[j])) begin
               match[i] = 1'b0;
            end
         end
      end
   end

   // first match in list order wins
   always_comb begin
      at_cfr_pkg::pattern_type q;
      code = at_cfr_pkg::CMD_UNKNOWN;
      for (int i = at_cfr_pkg::PATTERN_COUNT - 1; i >= 0; i--) begin
         q = at_cfr_pkg::pattern(at_cfr_pkg::PATTERN_IDX_W'(i));
         if (match[i]) begin
            code = q.code;
         end
      end
   end

   always_comb begin
      if (code inside {[at_cfr_pkg::CMD_AX:at_cfr_pkg::CMD_AA]}) begin
         payload = {view.bytes[5], view.bytes[4], view.bytes[3], view.bytes[2]};
      end else if (code inside {[at_cfr_pkg::CMD_AWR1:at_cfr_pkg::CMD_AGYS]}) begin
         payload = {view.bytes[7], view.bytes[6], view.bytes[5], view.bytes[4]};
      end else begin
         payload = '0;
      end
   end

   assign result.command        = code;
   assign result.payload        = payload;
   assign result.payload_is_nan = (payload[30:23] == 8'hFF) && (payload[22:0] != '0);

endmodule
